>>> design/bed_pkg.sv
// Shared types and constants for the button event detector.
// Used by the configuration interface and every module of the block; no dependencies.
package bed_pkg;

   // Default width of the wrapping tick counter
   localparam int TIME_BITS_DEFAULT = 32;

   // Configuration port sizes
   localparam int CSR_ADDR_BITS = 8;
   localparam int CSR_DATA_BITS = 16;

   // Event queue between front and back
   localparam int Q_DEPTH     = 4;
   localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

   // Most events one tick can raise
   localparam int MAX_EVENTS  = 3;

   // Register indexes on the configuration port
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      REG_DEBOUNCE   = 8'd0,
      REG_CLICK_MAX  = 8'd1,
      REG_CLICK_GAP  = 8'd2,
      REG_LONG_PRESS = 8'd3,
      REG_REP_PERIOD = 8'd4,
      REG_REP_DELAY  = 8'd5,
      REG_WORK_MODE  = 8'd6,
      REG_OPTIONS    = 8'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_STANDARD = 2'd0,
      MODE_FSM      = 2'd1,
      MODE_INSTANT  = 2'd2,
      MODE_REPEAT   = 2'd3
   } work_mode_type;

   typedef enum logic [3:0] {
      EVT_PRESS        = 4'd0,
      EVT_RELEASE      = 4'd1,
      EVT_LONG_RELEASE = 4'd2,
      EVT_CLICK        = 4'd3,
      EVT_LONG_PRESS   = 4'd4,
      EVT_REPEAT       = 4'd5,
      EVT_SINGLE       = 4'd6,
      EVT_DOUBLE       = 4'd7,
      EVT_TRIPLE       = 4'd8
   } evt_type;

   // Option bit positions
   localparam int OPT_ACTIVE_HIGH = 0;
   localparam int OPT_LONG_EN     = 1;
   localparam int OPT_REPEAT_EN   = 2;

   // Configuration register file contents
   typedef struct packed {
      logic [15:0]   debounce;
      logic [15:0]   click_max;
      logic [15:0]   click_gap;
      logic [15:0]   long_press;
      logic [15:0]   rep_period;
      logic [15:0]   rep_delay;
      work_mode_type mode;
      logic [2:0]    options;
   } cfg_type;

   // Events raised by one tick, in emission order
   typedef struct packed {
      logic [1:0]                  count;
      evt_type [MAX_EVENTS-1:0]    codes;
   } bundle_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> design/bed_if.sv
// Handshake channel interfaces of the button event detector: tick input,
// event output and configuration write. Depends on bed_pkg.
interface bed_req_if;
   logic valid;
   logic ready;
   logic raw_level;

   modport source (output valid, output raw_level, input ready);
   modport sink   (input valid, input raw_level, output ready);
endinterface

interface bed_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_code;
   logic       last_of_tick;

   modport source (output valid, output event_code, output last_of_tick, input ready);
   modport sink   (input valid, input event_code, input last_of_tick, output ready);
endinterface

interface bed_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bed_pkg::CSR_ADDR_BITS-1:0] addr;
   logic [bed_pkg::CSR_DATA_BITS-1:0] wdata;

   modport source (output valid, output addr, output wdata, input ready);
   modport sink   (input valid, input addr, input wdata, output ready);
endinterface

>>> design/bed_csr.sv
// Configuration registers of the button event detector.
// Depends on bed_pkg and bed_csr_if.
module bed_csr (
   input  logic              clock,
   input  logic              reset,
   bed_csr_if.sink           csr,
   output bed_pkg::cfg_type  cfg
);

   bed_pkg::cfg_type cfg_ff, cfg_in;

   // Always ready; writes to unknown indexes fall through
   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.addr)
            bed_pkg::REG_DEBOUNCE:   cfg_in.debounce   = csr.wdata;
            bed_pkg::REG_CLICK_MAX:  cfg_in.click_max  = csr.wdata;
            bed_pkg::REG_CLICK_GAP:  cfg_in.click_gap  = csr.wdata;
            bed_pkg::REG_LONG_PRESS: cfg_in.long_press = csr.wdata;
            bed_pkg::REG_REP_PERIOD: cfg_in.rep_period = csr.wdata;
            bed_pkg::REG_REP_DELAY:  cfg_in.rep_delay  = csr.wdata;
            bed_pkg::REG_WORK_MODE:  cfg_in.mode       = bed_pkg::work_mode_type'(csr.wdata[1:0]);
            bed_pkg::REG_OPTIONS:    cfg_in.options    = csr.wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce   <= 16'd20;
         cfg_ff.click_max  <= 16'd300;
         cfg_ff.click_gap  <= 16'd300;
         cfg_ff.long_press <= 16'd1000;
         cfg_ff.rep_period <= 16'd100;
         cfg_ff.rep_delay  <= 16'd500;
         cfg_ff.mode       <= bed_pkg::MODE_STANDARD;
         cfg_ff.options    <= 3'b110;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> design/bed_front.sv
// Front end: takes one tick item per cycle while the queue has room, runs
// debounce and the press, hold, repeat and click timers, and packs the raised
// events into a bundle. Depends on bed_pkg and bed_req_if.
module bed_front #(
   parameter int TIME_BITS = bed_pkg::TIME_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   bed_req_if.sink               req,
   input  bed_pkg::cfg_type      cfg,
   input  bed_pkg::q_status_type q_status,
   output logic                  push,
   output bed_pkg::bundle_type   bundle
);

   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic [TIME_BITS-1:0] last_chg_ff, last_chg_in;
   logic [TIME_BITS-1:0] press_ff, press_in;
   logic [TIME_BITS-1:0] release_ff, release_in;
   logic [TIME_BITS-1:0] last_rep_ff, last_rep_in;
   logic                 pressed_ff, pressed_in;
   logic                 long_ff, long_in;
   logic                 rep_seen_ff, rep_seen_in;
   logic [1:0]           tally_ff, tally_in;

   logic                 accept;
   logic                 level_on, clicky, change;
   logic                 ev_press, ev_release, ev_long_rel, ev_click;
   logic                 ev_long, ev_repeat, ev_report;
   logic [1:0]           tally_mid;
   logic [TIME_BITS-1:0] since_chg, held_old, held_new, since_rep, since_rel;
   logic [4:0]           cand_v;
   bed_pkg::evt_type     cand_c [5];
   bed_pkg::evt_type     report_code;
   logic [2:0]           n;

   assign req.ready = !q_status.full;
   assign accept    = req.valid && req.ready;

   // Debounce and press / release handling
   always_comb begin
      level_on  = (req.raw_level == cfg.options[bed_pkg::OPT_ACTIVE_HIGH]);
      clicky    = (cfg.mode == bed_pkg::MODE_STANDARD) || (cfg.mode == bed_pkg::MODE_FSM);
      since_chg = tick_ff - last_chg_ff;
      held_old  = tick_ff - press_ff;
      change    = (level_on != pressed_ff) && (since_chg >= TIME_BITS'(cfg.debounce));

      ev_press    = change && level_on;
      ev_release  = change && !level_on;
      ev_long_rel = ev_release && clicky && long_ff;
      ev_click    = ev_release && clicky && !long_ff && (held_old <= TIME_BITS'(cfg.click_max));

      last_chg_in = change ? tick_ff : last_chg_ff;
      pressed_in  = change ? level_on : pressed_ff;
      press_in    = ev_press ? tick_ff : press_ff;
      release_in  = ev_release ? tick_ff : release_ff;

      tally_mid = tally_ff;
      if (ev_long_rel) begin
         tally_mid = 2'd0;
      end else if (ev_click && (tally_ff != 2'd3)) begin
         tally_mid = tally_ff + 2'd1;
      end

      // Hold timers, on the state after the press / release step
      held_new = tick_ff - press_in;
      ev_long  = pressed_in && cfg.options[bed_pkg::OPT_LONG_EN] && !(long_ff && !ev_press)
                 && (held_new >= TIME_BITS'(cfg.long_press));
      long_in  = (long_ff && !ev_press) || ev_long;

      since_rep = tick_ff - (ev_press ? '0 : last_rep_ff);
      ev_repeat = pressed_in && (cfg.mode == bed_pkg::MODE_REPEAT)
                  && cfg.options[bed_pkg::OPT_REPEAT_EN]
                  && (held_new >= TIME_BITS'(cfg.rep_delay))
                  && (!(rep_seen_ff && !ev_press)
                      || (since_rep >= TIME_BITS'(cfg.rep_period)));
      last_rep_in = ev_repeat ? tick_ff : (ev_press ? '0 : last_rep_ff);
      rep_seen_in = ev_repeat || (rep_seen_ff && !ev_press);

      // Multi-click report once the release gap has run out
      since_rel = tick_ff - release_in;
      ev_report = (tally_mid != 2'd0) && !pressed_in && clicky
                  && (since_rel > TIME_BITS'(cfg.click_gap));
      tally_in  = ev_report ? 2'd0 : tally_mid;

      unique case (tally_mid)
         2'd1:    report_code = bed_pkg::EVT_SINGLE;
         2'd2:    report_code = bed_pkg::EVT_DOUBLE;
         default: report_code = bed_pkg::EVT_TRIPLE;
      endcase

      tick_in = tick_ff + 1'b1;
   end

   // Pack raised events into bundle slots, in emission order
   always_comb begin
      cand_v    = {ev_report, ev_repeat, ev_long, ev_long_rel || ev_click, ev_press || ev_release};
      cand_c[0] = ev_press ? bed_pkg::EVT_PRESS : bed_pkg::EVT_RELEASE;
      cand_c[1] = ev_long_rel ? bed_pkg::EVT_LONG_RELEASE : bed_pkg::EVT_CLICK;
      cand_c[2] = bed_pkg::EVT_LONG_PRESS;
      cand_c[3] = bed_pkg::EVT_REPEAT;
      cand_c[4] = report_code;
      n = 3'd0;
      bundle.codes = '{default: bed_pkg::EVT_PRESS};
      for (int i = 0; i < 5; i++) begin
         if (cand_v[i] && (n < 3'(bed_pkg::MAX_EVENTS))) begin
            bundle.codes[n[1:0]] = cand_c[i];
            n = n + 3'd1;
         end
      end
      bundle.count = n[1:0];
      push = accept && (n != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         last_chg_ff <= '0;
         press_ff    <= '0;
         release_ff  <= '0;
         last_rep_ff <= '0;
         pressed_ff  <= 1'b0;
         long_ff     <= 1'b0;
         rep_seen_ff <= 1'b0;
         tally_ff    <= 2'd0;
      end else if (accept) begin
         tick_ff     <= tick_in;
         last_chg_ff <= last_chg_in;
         press_ff    <= press_in;
         release_ff  <= release_in;
         last_rep_ff <= last_rep_in;
         pressed_ff  <= pressed_in;
         long_ff     <= long_in;
         rep_seen_ff <= rep_seen_in;
         tally_ff    <= tally_in;
      end
   end

endmodule

>>> design/bed_queue.sv
// Short bundle queue between the front end and the event sequencer.
// Depends on bed_pkg.
module bed_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bed_pkg::bundle_type   push_data,
   input  logic                  pop,
   output bed_pkg::bundle_type   head,
   output bed_pkg::q_status_type status
);

   bed_pkg::bundle_type                 slot_ff [bed_pkg::Q_DEPTH];
   logic [bed_pkg::Q_PTR_BITS-1:0]      wr_ff, wr_in, rd_ff, rd_in;
   logic [bed_pkg::Q_CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic                                do_push, do_pop;

   assign status.full  = (cnt_ff == bed_pkg::Q_CNT_BITS'(bed_pkg::Q_DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ff];

   // Pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == bed_pkg::Q_PTR_BITS'(bed_pkg::Q_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == bed_pkg::Q_PTR_BITS'(bed_pkg::Q_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Payload slots
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> design/bed_back.sv
// Back end: holds one bundle and hands its events out one item per cycle while
// rsp is ready, marking the last event of each tick. Depends on bed_pkg and bed_rsp_if.
module bed_back (
   input  logic                  clock,
   input  logic                  reset,
   input  bed_pkg::bundle_type   head,
   input  bed_pkg::q_status_type q_status,
   output logic                  pop,
   bed_rsp_if.source             rsp
);

   bed_pkg::bundle_type bnd_ff, bnd_in;
   logic                bvalid_ff, bvalid_in;
   logic [1:0]          pos_ff, pos_in;
   logic                last, fire;

   assign last             = (pos_ff == (bnd_ff.count - 2'd1));
   assign fire             = rsp.valid && rsp.ready;
   assign rsp.valid        = bvalid_ff;
   assign rsp.event_code   = bnd_ff.codes[pos_ff];
   assign rsp.last_of_tick = last;

   // Refill from the queue when empty or when the last event leaves
   assign pop = !q_status.empty && (!bvalid_ff || (fire && last));

   always_comb begin
      bnd_in    = bnd_ff;
      bvalid_in = bvalid_ff;
      pos_in    = pos_ff;
      if (fire) begin
         if (last) begin
            bvalid_in = 1'b0;
            pos_in    = 2'd0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
      if (pop) begin
         bnd_in    = head;
         bvalid_in = 1'b1;
         pos_in    = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= 1'b0;
         pos_ff    <= 2'd0;
      end else begin
         bvalid_ff <= bvalid_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      bnd_ff <= bnd_in;
   end

endmodule

>>> design/button_event_detector.sv
// Top level of the button event detector: config registers, front end,
// bundle queue and event sequencer. Depends on bed_pkg, bed_if and all bed_ modules.
//
//   channel | dir | payload                    | item
//   req     | in  | raw_level                  | one millisecond tick
//   rsp     | out | event_code, last_of_tick   | one button event
//   csr     | in  | addr, wdata                | one register write
//
// A tick is taken every cycle while the four-entry bundle queue has room;
// it is fully evaluated in its accept cycle and its events (up to three)
// leave rsp one per cycle while rsp is ready, so rsp throughput sets the
// sustained rate when ticks raise several events. The first event of a tick
// is registered in the bundle queue and then in the sequencer's bundle register
// before it is offered on rsp. Synchronous reset clears timers, queue and output;
// registers go to their defaults. A stalled rsp fills the queue, then drops req.ready.
module button_event_detector #(
   parameter int TIME_BITS = bed_pkg::TIME_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   bed_req_if.sink     req,
   bed_rsp_if.source   rsp,
   bed_csr_if.sink     csr
);

   bed_pkg::cfg_type      cfg;
   bed_pkg::bundle_type   bundle, head;
   bed_pkg::q_status_type q_status;
   logic                  push, pop;

   bed_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .cfg   (cfg)
   );

   bed_front #(.TIME_BITS(TIME_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .cfg      (cfg),
      .q_status (q_status),
      .push     (push),
      .bundle   (bundle)
   );

   bed_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   bed_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp)
   );

   // A bundle is never offered to a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("bundle pushed into full queue");

   // Once a non-last event of a tick leaves, the next event stays offered with no gap
   a_tick_contiguous : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && !rsp.last_of_tick) |=> rsp.valid)
      else $error("event stream broken inside a tick");

   // Nothing is offered right after reset
   a_reset_quiet : assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("event offered right after reset");

endmodule
